// ----- rtl/toi_pkg.sv -----
// shared types and constants of the trapezoid odometry integrator
package toi_pkg;

  localparam int unsigned TsW   = 32;
  localparam int unsigned VelW  = 16;
  localparam int unsigned AltW  = 20;
  localparam int unsigned StW   = 4;
  localparam int unsigned PosW  = 64;
  localparam int unsigned SumW  = VelW + 1;
  localparam int unsigned ProdW = SumW + TsW + 1;

  // flight state codes
  localparam logic [StW-1:0] FlyMinState      = 4'd3;
  localparam logic [StW-1:0] FlyExcludedState = 4'd5;

  typedef struct packed {
    logic        [TsW-1:0]  timestamp_us;
    logic signed [VelW-1:0] vel_x;
    logic signed [VelW-1:0] vel_y;
    logic        [AltW-1:0] altitude_mm;
    logic        [StW-1:0]  flight_state;
  } toi_in_t;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic        [AltW-1:0] pos_z;
  } toi_out_t;

endpackage

// ----- rtl/toi_in_if.sv -----
// request channel carrying navigation samples
interface toi_in_if;
  import toi_pkg::*;

  logic    valid;
  logic    ready;
  toi_in_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ----- rtl/toi_out_if.sv -----
// request channel carrying integrated positions
interface toi_out_if;
  import toi_pkg::*;

  logic     valid;
  logic     ready;
  toi_out_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

// ----- rtl/toi_axis_acc.sv -----
// saturating 64-bit position accumulator for one axis
module toi_axis_acc (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic signed [toi_pkg::ProdW-1:0]  step_i,
  output logic signed [toi_pkg::PosW-1:0]   acc_o
);
  import toi_pkg::*;

  logic signed [PosW-1:0] acc_q, acc_d;
  logic        [PosW:0]   wide_sum;

  // one guard bit shows overflow of the signed add
  assign wide_sum = {acc_q[PosW-1], acc_q}
                  + {{(PosW + 1 - ProdW){step_i[ProdW-1]}}, step_i};

  always_comb begin
    acc_d = acc_q;
    if (en_i) begin
      if (wide_sum[PosW] != wide_sum[PosW-1]) begin
        acc_d = wide_sum[PosW] ? {1'b1, {(PosW-1){1'b0}}} : {1'b0, {(PosW-1){1'b1}}};
      end else begin
        acc_d = wide_sum[PosW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ----- rtl/trapezoid_odometry_integrator.sv -----
// top level: trapezoid-rule dead reckoning of planar velocity samples
//
// in_i takes one navigation sample per request (time, X/Y velocity, altitude,
// flight state). out_o gives one position request per sample that is neither
// stale (time below the stored time) nor a seeding sample (stored time zero).
// Positions are in half-nanometre units and saturate at the signed 64-bit
// limits; Z is the last altitude seen while flying.
// Pipeline: sample stage (compare, dt, velocity sums), multiply stage, then the
// accumulate stage whose registers are the output. A position appears on out_o
// after its request moves from the sample and multiply registers into the accumulators.
// Throughput is one sample per cycle unless out_o stalls: the stored time and
// velocities update in the accept cycle and the accumulators close their loop
// with one 64-bit add. When out_o stalls, the stages behind it keep filling;
// in_i drops ready only once every stage holds a request.
// Reset clears the stored time, velocities, accumulators, altitude and all
// valid flags; the first sample after reset only seeds time and velocities.
module trapezoid_odometry_integrator (
  input  logic      clk_i,
  input  logic      rst_ni,
  toi_in_if.sink    in_i,
  toi_out_if.source out_o
);
  import toi_pkg::*;

  // stored sample state
  logic        [TsW-1:0]  last_time_q, last_time_d;
  logic signed [VelW-1:0] prev_vel_x_q, prev_vel_x_d;
  logic signed [VelW-1:0] prev_vel_y_q, prev_vel_y_d;
  logic        [AltW-1:0] height_q, height_d;

  // sample stage
  logic                   s1_valid_q, s1_valid_d;
  logic signed [SumW-1:0] s1_sum_x_q, s1_sum_y_q;
  logic        [TsW-1:0]  s1_dt_q;
  logic                   s1_fly_q;
  logic        [AltW-1:0] s1_alt_q;

  // multiply stage
  logic                    s2_valid_q, s2_valid_d;
  logic signed [ProdW-1:0] s2_prod_x_q, s2_prod_y_q;
  logic                    s2_fly_q;
  logic        [AltW-1:0]  s2_alt_q;

  logic out_valid_q, out_valid_d;

  logic                    accept, stale, seed, fly;
  logic                    out_free, s2_free, acc_en;
  logic signed [SumW-1:0]  sum_x, sum_y;
  logic        [TsW-1:0]   dt;
  logic signed [ProdW-1:0] prod_x, prod_y;
  logic signed [PosW-1:0]  acc_x, acc_y;

  assign out_free   = !out_valid_q || out_o.ready;
  assign s2_free    = !s2_valid_q || out_free;
  assign in_i.ready = !s1_valid_q || s2_free;
  assign accept     = in_i.valid && in_i.ready;

  assign stale = in_i.payload.timestamp_us < last_time_q;
  assign seed  = last_time_q == '0;
  assign fly   = (in_i.payload.flight_state >= FlyMinState)
              && (in_i.payload.flight_state != FlyExcludedState);
  assign dt    = in_i.payload.timestamp_us - last_time_q;
  assign sum_x = {in_i.payload.vel_x[VelW-1], in_i.payload.vel_x}
               + {prev_vel_x_q[VelW-1], prev_vel_x_q};
  assign sum_y = {in_i.payload.vel_y[VelW-1], in_i.payload.vel_y}
               + {prev_vel_y_q[VelW-1], prev_vel_y_q};

  always_comb begin
    last_time_d  = last_time_q;
    prev_vel_x_d = prev_vel_x_q;
    prev_vel_y_d = prev_vel_y_q;
    if (accept && !stale) begin
      last_time_d  = in_i.payload.timestamp_us;
      prev_vel_x_d = in_i.payload.vel_x;
      prev_vel_y_d = in_i.payload.vel_y;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_i.ready) begin
      s1_valid_d = accept && !stale && !seed;
    end
    s2_valid_d = s2_valid_q;
    if (s2_free) begin
      s2_valid_d = s1_valid_q;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = s2_valid_q;
    end
  end

  // dt is unsigned, so it gets a zero sign bit
  assign prod_x = s1_sum_x_q * $signed({1'b0, s1_dt_q});
  assign prod_y = s1_sum_y_q * $signed({1'b0, s1_dt_q});

  assign acc_en   = s2_valid_q && out_free && s2_fly_q;
  assign height_d = acc_en ? s2_alt_q : height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q  <= '0;
      prev_vel_x_q <= '0;
      prev_vel_y_q <= '0;
      height_q     <= '0;
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      last_time_q  <= last_time_d;
      prev_vel_x_q <= prev_vel_x_d;
      prev_vel_y_q <= prev_vel_y_d;
      height_q     <= height_d;
      s1_valid_q   <= s1_valid_d;
      s2_valid_q   <= s2_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready) begin
      s1_sum_x_q <= sum_x;
      s1_sum_y_q <= sum_y;
      s1_dt_q    <= dt;
      s1_fly_q   <= fly;
      s1_alt_q   <= in_i.payload.altitude_mm;
    end
    if (s2_free) begin
      s2_prod_x_q <= prod_x;
      s2_prod_y_q <= prod_y;
      s2_fly_q    <= s1_fly_q;
      s2_alt_q    <= s1_alt_q;
    end
  end

  toi_axis_acc u_acc_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (acc_en),
    .step_i (s2_prod_x_q),
    .acc_o  (acc_x)
  );

  toi_axis_acc u_acc_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (acc_en),
    .step_i (s2_prod_y_q),
    .acc_o  (acc_y)
  );

  assign out_o.valid         = out_valid_q;
  assign out_o.payload.pos_x = acc_x;
  assign out_o.payload.pos_y = acc_y;
  assign out_o.payload.pos_z = height_q;

  // an empty sample stage always takes a request
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_i.ready)
    else $error("input not ready with empty sample stage");

  // seeding samples never enter the pipeline
  a_seed_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && seed |=> !s1_valid_q)
    else $error("seeding sample produced a result");

  // stale samples leave the stored time alone
  a_stale_keeps_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && stale |=> last_time_q == $past(last_time_q))
    else $error("stale sample changed stored time");

  // a non-flying result holds the position
  a_ground_holds_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && out_free && !s2_fly_q |=> acc_x == $past(acc_x) && acc_y == $past(acc_y))
    else $error("position moved while not flying");

endmodule

// ----- sim/toi_checker.sv -----
// position predictor and comparator that watches both request channels
`timescale 1ns / 100ps

module toi_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  toi_pkg::toi_in_t  in_req_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  toi_pkg::toi_out_t out_pos_i,
  output int                fail_count_o,
  output int                pending_o
);
  import toi_pkg::*;

  localparam logic signed [PosW-1:0] PosMax = {1'b0, {(PosW-1){1'b1}}};
  localparam logic signed [PosW-1:0] PosMin = {1'b1, {(PosW-1){1'b0}}};

  logic        [TsW-1:0]  last_ts;
  logic signed [VelW-1:0] prev_vx;
  logic signed [VelW-1:0] prev_vy;
  logic signed [PosW-1:0] pos_x;
  logic signed [PosW-1:0] pos_y;
  logic        [AltW-1:0] height;
  toi_out_t               expected_pos_q[$];

  function automatic logic signed [PosW-1:0] sat_accum(input logic signed [PosW-1:0] acc,
                                                       input longint step);
    logic [PosW:0] sum;
    sum = {acc[PosW-1], acc} + {step[63], step};
    // sign of the wide sum disagrees with bit 63 only on overflow
    if (sum[PosW] != sum[PosW-1]) begin
      return sum[PosW] ? PosMin : PosMax;
    end
    return sum[PosW-1:0];
  endfunction

  // (v + v_prev) * dt is the displacement in half-nanometre units
  function automatic longint trapezoid_step(input logic signed [VelW-1:0] vel,
                                            input logic signed [VelW-1:0] vel_prev,
                                            input logic [TsW-1:0] dt);
    longint vel_sum;
    vel_sum = longint'(vel) + longint'(vel_prev);
    return vel_sum * longint'({32'b0, dt});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track_position
    toi_out_t         want;
    logic [TsW-1:0]   dt;
    if (!rst_ni) begin
      last_ts = '0;
      prev_vx = '0;
      prev_vy = '0;
      pos_x = '0;
      pos_y = '0;
      height = '0;
      expected_pos_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_pos_q.size() == 0) begin
          $error("position with no sample pending: pos_x %0d pos_y %0d pos_z %0d",
                 out_pos_i.pos_x, out_pos_i.pos_y, out_pos_i.pos_z);
          fail_count_o++;
        end else begin
          want = expected_pos_q.pop_front();
          if (out_pos_i.pos_x !== want.pos_x) begin
            $error("pos_x: expected %0d, got %0d", want.pos_x, out_pos_i.pos_x);
            fail_count_o++;
          end
          if (out_pos_i.pos_y !== want.pos_y) begin
            $error("pos_y: expected %0d, got %0d", want.pos_y, out_pos_i.pos_y);
            fail_count_o++;
          end
          if (out_pos_i.pos_z !== want.pos_z) begin
            $error("pos_z: expected %0d, got %0d", want.pos_z, out_pos_i.pos_z);
            fail_count_o++;
          end
        end
      end
      // stale samples fall through untouched
      if (in_valid_i && in_ready_i && in_req_i.timestamp_us >= last_ts) begin
        if (last_ts == '0) begin
          last_ts = in_req_i.timestamp_us;
          prev_vx = in_req_i.vel_x;
          prev_vy = in_req_i.vel_y;
        end else begin
          dt = in_req_i.timestamp_us - last_ts;
          last_ts = in_req_i.timestamp_us;
          if (in_req_i.flight_state >= FlyMinState &&
              in_req_i.flight_state != FlyExcludedState) begin
            pos_x = sat_accum(pos_x, trapezoid_step(in_req_i.vel_x, prev_vx, dt));
            pos_y = sat_accum(pos_y, trapezoid_step(in_req_i.vel_y, prev_vy, dt));
            height = in_req_i.altitude_mm;
          end
          prev_vx = in_req_i.vel_x;
          prev_vy = in_req_i.vel_y;
          want.pos_x = pos_x;
          want.pos_y = pos_y;
          want.pos_z = height;
          expected_pos_q.push_back(want);
        end
      end
      pending_o = expected_pos_q.size();
    end
  end

endmodule

// ----- sim/tb.sv -----
// testbench top: sample stimulus, random backpressure, watchdog and verdict
`timescale 1ns / 100ps

module tb;
  import toi_pkg::*;

  localparam int unsigned NumRandom   = 1700;
  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned CalmFirst   = 500;
  localparam int unsigned CalmLast    = 800;

  logic           clk;
  logic           rst_n;
  logic           calm;
  logic [TsW-1:0] cur_ts;
  int             fail_count;
  int             pending;
  int             quiet_cycles;

  toi_in_if  in_ch ();
  toi_out_if out_ch ();

  trapezoid_odometry_integrator u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  toi_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_ch.valid),
    .in_ready_i   (in_ch.ready),
    .in_req_i     (in_ch.payload),
    .out_valid_i  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_pos_i    (out_ch.payload),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_ch.ready <= calm || ($urandom_range(0, 99) >= 15);
  end

  // watchdog: cycles in which neither channel moves a request
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic toi_in_t make_sample(input logic [TsW-1:0] ts,
                                          input logic signed [VelW-1:0] vx,
                                          input logic signed [VelW-1:0] vy,
                                          input logic [AltW-1:0] alt,
                                          input logic [StW-1:0] st);
    toi_in_t req;
    req.timestamp_us = ts;
    req.vel_x = vx;
    req.vel_y = vy;
    req.altitude_mm = alt;
    req.flight_state = st;
    return req;
  endfunction

  function automatic logic signed [VelW-1:0] pick_vel();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(VelW-1){1'b1}}};
      1: return {1'b1, {(VelW-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return VelW'($urandom);
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send_sample(input toi_in_t req);
    while (!calm && $urandom_range(0, 99) < 15) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= req;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int            n;
    int            pick;
    logic [TsW:0]  next_ts;
    toi_in_t       req;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    calm = 1'b0;
    rst_n = 1'b0;
    cur_ts = '0;
    quiet_cycles = 0;
    n = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // time zero keeps the block seeding
    send_sample(make_sample('0, 16'sh7FFF, -16'sh8000, '1, FlyMinState));
    send_sample(make_sample('0, -16'sd1, 16'sd1, '0, FlyExcludedState));
    send_sample(make_sample(32'd1000, -16'sh8000, 16'sh7FFF, 20'h12345, FlyMinState));
    // stale, then an equal timestamp with zero dt
    send_sample(make_sample(32'd500, 16'sd100, 16'sd100, 20'd7, FlyMinState));
    send_sample(make_sample(32'd1000, 16'sh7FFF, 16'sh7FFF, 20'h54321, FlyMinState));
    cur_ts = 32'd1000;
    for (int st = 0; st < 16; st++) begin
      cur_ts = cur_ts + 32'd1000 + st;
      send_sample(make_sample(cur_ts, st[0] ? -16'sh8000 : 16'sh7FFF,
                              st[0] ? 16'sh7FFF : -16'sh8000,
                              st[0] ? '1 : '0, st[StW-1:0]));
    end
    cur_ts = cur_ts + 32'h0100_0000;
    send_sample(make_sample(cur_ts, 16'sh7FFF, 16'sh7FFF, 20'hABCDE, FlyMinState));

    while (n < NumRandom) begin
      calm <= (n >= CalmFirst && n < CalmLast);
      pick = $urandom_range(0, 99);
      req = make_sample(cur_ts, pick_vel(), pick_vel(), AltW'($urandom), StW'($urandom));
      if (pick < 8 && cur_ts != '0) begin
        req.timestamp_us = $urandom_range(0, cur_ts - 1);
      end else begin
        if (n >= NumRandom - 20) begin
          next_ts = {1'b0, {TsW{1'b1}}};
        end else if (pick < 16) begin
          next_ts = {1'b0, cur_ts};
        end else if (pick < 22) begin
          next_ts = cur_ts + $urandom_range(1 << 20, 1 << 24);
        end else begin
          next_ts = cur_ts + $urandom_range(1, 4000);
        end
        // one jump across the top half of the time range
        if (n == 1000) next_ts = next_ts + 33'h0_8000_0000;
        if (next_ts[TsW]) next_ts = {1'b0, {TsW{1'b1}}};
        cur_ts = next_ts[TsW-1:0];
        req.timestamp_us = cur_ts;
        n++;
      end
      send_sample(req);
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
